### hw/rtl/tct_pkg.sv
// shared types, constants and widths of the cabinet thermostat
`timescale 1ns / 1ps
`default_nettype none

package tct_pkg;

    // temperature in degrees, signed
    typedef logic signed [8:0] t_temp;
    // temperature widened by one bit for threshold +/- 1
    typedef logic signed [9:0] t_temp_ext;

    // sensor select codes
    localparam logic [1:0] SEL_FIRST  = 2'd0;
    localparam logic [1:0] SEL_SECOND = 2'd1;
    localparam logic [1:0] SEL_FAILED = 2'd2;

    // fault flag bit positions
    localparam int FLAG_BOTH_FAILED  = 0;
    localparam int FLAG_FAILED_OVER  = 1;

    // configuration register indexes
    localparam logic CFG_FAN_TH    = 1'b0;
    localparam logic CFG_HEATER_TH = 1'b1;

    localparam t_temp FAN_TH_RESET    = 9'sd35;
    localparam t_temp HEATER_TH_RESET = 9'sd5;

    // converter conversion and plausibility limits
    localparam t_temp CODE_OFFSET     = 9'sd75;
    localparam t_temp TEMP_HIGH_LIMIT = 9'sd45;
    localparam t_temp TEMP_LOW_LIMIT  = -9'sd12;

    // error and repeat limits
    localparam logic [2:0] ERROR_LIMIT  = 3'd5;
    localparam logic [2:0] ERROR_MAX    = 3'd7;
    localparam logic [2:0] REPEAT_LIMIT = 3'd5;

    // daily stuck-reading windows
    localparam logic [4:0] WINDOW_HOUR_AM = 5'd3;
    localparam logic [4:0] WINDOW_HOUR_PM = 5'd15;
    localparam logic [5:0] WINDOW_MINUTES = 6'd3;

    // history line and warm-up
    localparam int HISTORY_DEPTH  = 24;
    localparam int HISTORY_PERIOD = 60;
    localparam int WARMUP_SAMPLES = 1445;
    localparam int TICK_W = $clog2(HISTORY_PERIOD + 2);
    localparam int WARM_W = $clog2(WARMUP_SAMPLES + 1);
    localparam logic [TICK_W-1:0] TICK_LIMIT = TICK_W'(HISTORY_PERIOD);
    localparam logic [WARM_W-1:0] WARM_LIMIT = WARM_W'(WARMUP_SAMPLES);

    // supply scaling: code*16/100 = code*41 >> 8 exact for 8-bit codes,
    // then x*25/15 = (x*5)*171 >> 9 exact for x up to 40
    localparam logic [5:0] RECIP_25  = 6'd41;
    localparam int         RECIP_25_SHIFT = 8;
    localparam logic [7:0] RECIP_3   = 8'd171;
    localparam int         RECIP_3_SHIFT = 9;

    // relay request and result
    typedef struct packed {
        logic force_off;
        logic drive;
        logic on_req;
        logic off_req;
    } t_relay_req;

    typedef struct packed {
        logic relay;
        logic cmd;
    } t_relay_out;

endpackage

`default_nettype wire

### hw/rtl/cabinet_thermostat_with_sensor_failover.sv
// top level: cabinet thermostat with sensor failover, input and result registers
//
// channel  | direction | handshake                | contents
// ---------+-----------+--------------------------+-----------------------------------
// in       | in        | i_in_valid / o_in_ready  | sensor, supply codes, hour, minute
// out      | out       | o_out_valid / i_out_ready| temperature, relays, status, supplies
// cfg      | in        | i_cfg_we                 | i_cfg_index, i_cfg_data (thresholds)
//
// one word per cycle sustained while the result side takes each word: a word waits in
// the input register, then its whole sample update runs in one pass of shallow logic
// and lands in the result register, which raises o_out_valid.
// synchronous active-low reset clears all control state, history and counters.
// a stalled result holds the result register; the input register still takes a word
// while it is empty, or while the result register is free or being emptied in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module cabinet_thermostat_with_sensor_failover (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [8:0]        i_cfg_data,
    // input channel
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [7:0]        i_sensor_a_code,
    input  wire logic [7:0]        i_sensor_b_code,
    input  wire logic [7:0]        i_supply_a_code,
    input  wire logic [7:0]        i_supply_b_code,
    input  wire logic [4:0]        i_hour,
    input  wire logic [5:0]        i_minute,
    // output channel
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic signed [8:0]      o_temperature,
    output logic                   o_fan_on,
    output logic                   o_fan_command,
    output logic                   o_heater_on,
    output logic                   o_heater_command,
    output logic [1:0]             o_active_sensor,
    output logic [1:0]             o_status_flags,
    output logic [2:0]             o_error_count,
    output logic                   o_sample_accepted,
    output logic [7:0]             o_supply_a_volts,
    output logic [7:0]             o_supply_b_volts,
    output logic signed [8:0]      o_history_newest
);

    localparam int DEPTH  = tct_pkg::HISTORY_DEPTH;
    localparam int TICK_W = tct_pkg::TICK_W;
    localparam int WARM_W = tct_pkg::WARM_W;

    // thresholds
    tct_pkg::t_temp r_fan_th;
    tct_pkg::t_temp r_heater_th;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_sensor_a;
    logic [7:0]  r_sensor_b;
    logic [7:0]  r_supply_a;
    logic [7:0]  r_supply_b;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute;

    // sample state
    logic [1:0]        r_sel,     n_sel;
    logic [1:0]        r_flags,   n_flags;
    logic [2:0]        r_err,     n_err;
    logic [TICK_W-1:0] r_tick,    n_tick;
    logic [WARM_W-1:0] r_warm,    n_warm;
    tct_pkg::t_temp    r_morning, n_morning;
    tct_pkg::t_temp    r_afternoon, n_afternoon;
    tct_pkg::t_temp    r_hist [DEPTH];
    tct_pkg::t_temp    n_hist [DEPTH];
    logic [7:0]        r_volts_a, n_volts_a;
    logic [7:0]        r_volts_b, n_volts_b;

    // result register
    logic              r_out_valid;
    tct_pkg::t_temp    r_out_temp;
    logic              r_out_fan_on;
    logic              r_out_fan_cmd;
    logic              r_out_heater_on;
    logic              r_out_heater_cmd;
    logic [1:0]        r_out_sel;
    logic [1:0]        r_out_flags;
    logic [2:0]        r_out_err;
    logic              r_out_acc;
    logic [7:0]        r_out_volts_a;
    logic [7:0]        r_out_volts_b;
    tct_pkg::t_temp    r_out_hist;

    // combinational work
    logic                advance;
    tct_pkg::t_temp      temp;
    tct_pkg::t_temp      out_temp;
    tct_pkg::t_temp_ext  temp_x;
    tct_pkg::t_temp_ext  fan_off_th;
    tct_pkg::t_temp_ext  heater_off_th;
    logic [2:0]          err_base;
    logic [2:0]          err_bump;
    logic                win_am;
    logic                win_pm;
    logic                fail_now;
    logic                drive;
    logic                force_off;
    logic                acc;
    logic [7:0]          scaled_a;
    logic [7:0]          scaled_b;
    tct_pkg::t_relay_req fan_req;
    tct_pkg::t_relay_req heater_req;
    tct_pkg::t_relay_out fan_next;
    tct_pkg::t_relay_out heater_next;

    // handshake
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;

    // temperature and hysteresis bounds
    assign temp = (r_sel == tct_pkg::SEL_SECOND)
                ? $signed({1'b0, r_sensor_b}) - tct_pkg::CODE_OFFSET
                : $signed({1'b0, r_sensor_a}) - tct_pkg::CODE_OFFSET;
    assign temp_x        = {temp[8], temp};
    assign fan_off_th    = $signed({r_fan_th[8], r_fan_th}) - 10'sd1;
    assign heater_off_th = $signed({r_heater_th[8], r_heater_th}) + 10'sd1;
    assign win_am = (r_hour == tct_pkg::WINDOW_HOUR_AM) && (r_minute < tct_pkg::WINDOW_MINUTES);
    assign win_pm = (r_hour == tct_pkg::WINDOW_HOUR_PM) && (r_minute < tct_pkg::WINDOW_MINUTES);

    tct_supply_scale u_supply (
        .i_code_a  (r_supply_a),
        .i_code_b  (r_supply_b),
        .o_volts_a (scaled_a),
        .o_volts_b (scaled_b)
    );

    // per-sample state update
    always_comb begin
        n_sel       = r_sel;
        n_flags     = r_flags;
        n_err       = r_err;
        n_tick      = r_tick;
        n_warm      = r_warm;
        n_morning   = r_morning;
        n_afternoon = r_afternoon;
        n_hist      = r_hist;
        n_volts_a   = r_volts_a;
        n_volts_b   = r_volts_b;
        out_temp    = temp;
        err_base    = r_err;
        err_bump    = r_err;
        fail_now    = 1'b0;
        drive       = 1'b0;
        force_off   = 1'b0;
        acc         = 1'b0;
        if (r_sel == tct_pkg::SEL_FAILED) begin
            force_off = 1'b1;
            out_temp  = '0;
        end else begin
            // history line advances once per HISTORY_PERIOD + 1 samples
            if (r_tick > tct_pkg::TICK_LIMIT) begin
                for (int i = 1; i < DEPTH; i++) begin
                    n_hist[i] = r_hist[i-1];
                end
                n_hist[0] = temp;
                n_tick    = TICK_W'(1);
            end else begin
                n_tick = r_tick + TICK_W'(1);
            end
            // failover on too many errors
            if (r_err > tct_pkg::ERROR_LIMIT) begin
                if (r_sel == tct_pkg::SEL_FIRST) begin
                    n_sel = tct_pkg::SEL_SECOND;
                    n_flags[tct_pkg::FLAG_FAILED_OVER] = 1'b1;
                    err_base = 3'd0;
                    n_err    = 3'd0;
                end else begin
                    n_sel = tct_pkg::SEL_FAILED;
                    n_flags[tct_pkg::FLAG_BOTH_FAILED] = 1'b1;
                    force_off = 1'b1;
                    out_temp  = '0;
                    fail_now  = 1'b1;
                end
            end
            err_bump = (err_base == tct_pkg::ERROR_MAX) ? err_base : err_base + 3'd1;
            if (!fail_now) begin
                if (temp > tct_pkg::TEMP_HIGH_LIMIT || temp < tct_pkg::TEMP_LOW_LIMIT) begin
                    n_err = err_bump;
                end else begin
                    if (win_am) begin
                        n_morning = temp;
                    end
                    if (win_pm) begin
                        n_afternoon = temp;
                    end
                    if (r_warm < tct_pkg::WARM_LIMIT) begin
                        n_warm = r_warm + WARM_W'(1);
                    end
                    if (r_warm >= tct_pkg::WARM_LIMIT && (win_am || win_pm)
                            && n_morning == n_afternoon) begin
                        // stuck reading
                        n_err = err_bump;
                    end else begin
                        n_err     = 3'd0;
                        drive     = 1'b1;
                        acc       = 1'b1;
                        n_volts_a = scaled_a;
                        n_volts_b = scaled_b;
                    end
                end
            end
        end
    end

    // relay requests
    assign fan_req.force_off    = force_off;
    assign fan_req.drive        = drive;
    assign fan_req.on_req       = temp >= r_fan_th;
    assign fan_req.off_req      = temp_x < fan_off_th;
    assign heater_req.force_off = force_off;
    assign heater_req.drive     = drive;
    assign heater_req.on_req    = temp <= r_heater_th;
    assign heater_req.off_req   = temp_x > heater_off_th;

    tct_relay_ctrl u_fan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_req     (fan_req),
        .o_next    (fan_next)
    );

    tct_relay_ctrl u_heater (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_req     (heater_req),
        .o_next    (heater_next)
    );

    // threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fan_th    <= tct_pkg::FAN_TH_RESET;
            r_heater_th <= tct_pkg::HEATER_TH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tct_pkg::CFG_FAN_TH:    r_fan_th    <= i_cfg_data;
                tct_pkg::CFG_HEATER_TH: r_heater_th <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_sensor_a <= i_sensor_a_code;
            r_sensor_b <= i_sensor_b_code;
            r_supply_a <= i_supply_a_code;
            r_supply_b <= i_supply_b_code;
            r_hour     <= i_hour;
            r_minute   <= i_minute;
        end
    end

    // sample state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel       <= tct_pkg::SEL_FIRST;
            r_flags     <= 2'b00;
            r_err       <= 3'd0;
            r_tick      <= '0;
            r_warm      <= '0;
            r_morning   <= '0;
            r_afternoon <= '0;
            r_volts_a   <= 8'd0;
            r_volts_b   <= 8'd0;
            for (int i = 0; i < DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else if (advance) begin
            r_sel       <= n_sel;
            r_flags     <= n_flags;
            r_err       <= n_err;
            r_tick      <= n_tick;
            r_warm      <= n_warm;
            r_morning   <= n_morning;
            r_afternoon <= n_afternoon;
            r_volts_a   <= n_volts_a;
            r_volts_b   <= n_volts_b;
            r_hist      <= n_hist;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_temp       <= out_temp;
            r_out_fan_on     <= fan_next.relay;
            r_out_fan_cmd    <= fan_next.cmd;
            r_out_heater_on  <= heater_next.relay;
            r_out_heater_cmd <= heater_next.cmd;
            r_out_sel        <= n_sel;
            r_out_flags      <= n_flags;
            r_out_err        <= n_err;
            r_out_acc        <= acc;
            r_out_volts_a    <= n_volts_a;
            r_out_volts_b    <= n_volts_b;
            r_out_hist       <= n_hist[0];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_temperature     = r_out_temp;
    assign o_fan_on          = r_out_fan_on;
    assign o_fan_command     = r_out_fan_cmd;
    assign o_heater_on       = r_out_heater_on;
    assign o_heater_command  = r_out_heater_cmd;
    assign o_active_sensor   = r_out_sel;
    assign o_status_flags    = r_out_flags;
    assign o_error_count     = r_out_err;
    assign o_sample_accepted = r_out_acc;
    assign o_supply_a_volts  = r_out_volts_a;
    assign o_supply_b_volts  = r_out_volts_b;
    assign o_history_newest  = r_out_hist;

    // failed state is terminal
    a_failed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel == tct_pkg::SEL_FAILED |=> r_sel == tct_pkg::SEL_FAILED)
        else $error("failed state left");

    // failed state implies both fault flags
    a_failed_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel == tct_pkg::SEL_FAILED |-> r_flags == 2'b11)
        else $error("failed state without both fault flags");

    // a failed result never shows a relay on
    a_failed_relays_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sel == tct_pkg::SEL_FAILED) |-> (!r_out_fan_on && !r_out_heater_on))
        else $error("relay on in failed state");

    // a word in the input register moves on when the result side is free
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> r_out_valid)
        else $error("word stuck in input register");

endmodule

`default_nettype wire

### hw/rtl/tct_supply_scale.sv
// supply voltage scaling of both channels by constant reciprocals
`timescale 1ns / 1ps
`default_nettype none

module tct_supply_scale (
    input  wire logic [7:0] i_code_a,
    input  wire logic [7:0] i_code_b,
    output logic [7:0]      o_volts_a,
    output logic [7:0]      o_volts_b
);

    logic [13:0] prod_a;
    logic [13:0] prod_b;
    logic [5:0]  base_a;
    logic [5:0]  base_b;
    logic [7:0]  five_a;
    logic [15:0] third_a;

    // code*16/100 on both channels
    assign prod_a = 14'(i_code_a) * 14'(tct_pkg::RECIP_25);
    assign prod_b = 14'(i_code_b) * 14'(tct_pkg::RECIP_25);
    assign base_a = prod_a[tct_pkg::RECIP_25_SHIFT +: 6];
    assign base_b = prod_b[tct_pkg::RECIP_25_SHIFT +: 6];

    // channel a times 25/15
    assign five_a  = 8'(base_a) * 8'd5;
    assign third_a = 16'(five_a) * 16'(tct_pkg::RECIP_3);
    assign o_volts_a = {1'b0, third_a[tct_pkg::RECIP_3_SHIFT +: 7]};

    // channel b times 8, wrapped
    assign o_volts_b = {base_b[4:0], 3'b000};

endmodule

`default_nettype wire

### hw/rtl/tct_relay_ctrl.sv
// one relay with hysteresis requests and repeat-limited commands
`timescale 1ns / 1ps
`default_nettype none

module tct_relay_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_advance,
    input  wire tct_pkg::t_relay_req i_req,
    output tct_pkg::t_relay_out      o_next
);

    logic       r_relay;
    logic [2:0] r_cnt_on;
    logic [2:0] r_cnt_off;
    logic       n_relay;
    logic [2:0] n_cnt_on;
    logic [2:0] n_cnt_off;
    logic       n_cmd;

    // next relay state and command for the word in flight
    always_comb begin
        n_relay   = r_relay;
        n_cnt_on  = r_cnt_on;
        n_cnt_off = r_cnt_off;
        n_cmd     = 1'b0;
        if (i_req.force_off) begin
            n_relay = 1'b0;
            n_cmd   = 1'b1;
        end else if (i_req.drive) begin
            if (i_req.on_req) begin
                if (r_cnt_on < tct_pkg::REPEAT_LIMIT) begin
                    n_relay   = 1'b1;
                    n_cnt_on  = r_cnt_on + 3'd1;
                    n_cnt_off = 3'd0;
                    n_cmd     = 1'b1;
                end
            end else if (i_req.off_req) begin
                if (r_cnt_off < tct_pkg::REPEAT_LIMIT) begin
                    n_relay   = 1'b0;
                    n_cnt_off = r_cnt_off + 3'd1;
                    n_cnt_on  = 3'd0;
                    n_cmd     = 1'b1;
                end
            end
        end
    end

    assign o_next.relay = n_relay;
    assign o_next.cmd   = n_cmd;

    // relay and repeat counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay   <= 1'b0;
            r_cnt_on  <= 3'd0;
            r_cnt_off <= 3'd0;
        end else if (i_advance) begin
            r_relay   <= n_relay;
            r_cnt_on  <= n_cnt_on;
            r_cnt_off <= n_cnt_off;
        end
    end

endmodule

`default_nettype wire

### bench/tb_cabinet_thermostat_with_sensor_failover.sv
// self-checking testbench for the cabinet thermostat: directed rows, then random phases
`timescale 1ns / 1ps

module tb_cabinet_thermostat_with_sensor_failover;

    typedef struct packed {
        logic [7:0] sens_a;
        logic [7:0] sens_b;
        logic [7:0] sup_a;
        logic [7:0] sup_b;
        logic [4:0] hour;
        logic [5:0] minute;
    } t_sample;

    typedef struct packed {
        tct_pkg::t_temp temperature;
        logic           fan_on;
        logic           fan_cmd;
        logic           heater_on;
        logic           heater_cmd;
        logic [1:0]     sensor;
        logic [1:0]     flags;
        logic [2:0]     errs;
        logic           accepted;
        logic [7:0]     volts_a;
        logic [7:0]     volts_b;
        tct_pkg::t_temp newest;
    } t_reading;

    typedef struct packed {
        logic     typed;
        t_sample  smp;
        t_reading want;
    } t_row;

    // clock and stimulus signals, all known from time zero
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_index = tct_pkg::CFG_FAN_TH;
    logic [8:0]  i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    t_sample     in_word     = '0;
    logic        i_out_ready = 1'b0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic signed [8:0] o_temperature;
    logic        o_fan_on;
    logic        o_fan_command;
    logic        o_heater_on;
    logic        o_heater_command;
    logic [1:0]  o_active_sensor;
    logic [1:0]  o_status_flags;
    logic [2:0]  o_error_count;
    logic        o_sample_accepted;
    logic [7:0]  o_supply_a_volts;
    logic [7:0]  o_supply_b_volts;
    logic signed [8:0] o_history_newest;

    // readings still owed by the block, oldest first
    t_reading due_readings[$];
    int       mismatches = 0;
    int       ready_hold = 0;

    // thermostat state as the bench sees it
    tct_pkg::t_temp fan_limit  = tct_pkg::FAN_TH_RESET;
    tct_pkg::t_temp heat_limit = tct_pkg::HEATER_TH_RESET;
    logic [1:0] sensor_in_use  = tct_pkg::SEL_FIRST;
    logic [1:0] fault_bits     = '0;
    logic [2:0] err_cnt        = '0;
    int         hist_tick      = 0;
    tct_pkg::t_temp temp_log [tct_pkg::HISTORY_DEPTH];
    int         morning_temp   = 0;
    int         afternoon_temp = 0;
    int         warm_cnt       = 0;
    logic       fan_relay      = 1'b0;
    logic       heat_relay     = 1'b0;
    int         rep_count [4]  = '{0, 0, 0, 0};
    logic [7:0] volts_a        = '0;
    logic [7:0] volts_b        = '0;

    // directed rows; typed rows carry an expectation read straight off the spec
    t_row directed_rows [20] = '{
        '{1'b1, '{8'd100, 8'd0, 8'd0, 8'd0, 5'd0, 6'd0},
              '{9'sd25, 1'b0, 1'b1, 1'b0, 1'b1, tct_pkg::SEL_FIRST, 2'b00, 3'd0, 1'b1,
                8'd0, 8'd0, 9'sd0}},
        '{1'b1, '{8'd120, 8'd255, 8'd255, 8'd255, 5'd23, 6'd59},
              '{9'sd45, 1'b1, 1'b1, 1'b0, 1'b1, tct_pkg::SEL_FIRST, 2'b00, 3'd0, 1'b1,
                8'd66, 8'd64, 9'sd0}},
        '{1'b1, '{8'd63, 8'd128, 8'd0, 8'd0, 5'd31, 6'd63},
              '{-9'sd12, 1'b0, 1'b1, 1'b1, 1'b1, tct_pkg::SEL_FIRST, 2'b00, 3'd0, 1'b1,
                8'd0, 8'd0, 9'sd0}},
        '{1'b1, '{8'd0, 8'd255, 8'd255, 8'd255, 5'd3, 6'd0},
              '{-9'sd75, 1'b0, 1'b0, 1'b1, 1'b0, tct_pkg::SEL_FIRST, 2'b00, 3'd1, 1'b0,
                8'd0, 8'd0, 9'sd0}},
        '{1'b1, '{8'd255, 8'd0, 8'd255, 8'd0, 5'd15, 6'd1},
              '{9'sd180, 1'b0, 1'b0, 1'b1, 1'b0, tct_pkg::SEL_FIRST, 2'b00, 3'd2, 1'b0,
                8'd0, 8'd0, 9'sd0}},
        '{1'b1, '{8'd121, 8'd1, 8'd1, 8'd254, 5'd1, 6'd2},
              '{9'sd46, 1'b0, 1'b0, 1'b1, 1'b0, tct_pkg::SEL_FIRST, 2'b00, 3'd3, 1'b0,
                8'd0, 8'd0, 9'sd0}},
        '{1'b1, '{8'd62, 8'd254, 8'd128, 8'd127, 5'd16, 6'd32},
              '{-9'sd13, 1'b0, 1'b0, 1'b1, 1'b0, tct_pkg::SEL_FIRST, 2'b00, 3'd4, 1'b0,
                8'd0, 8'd0, 9'sd0}},
        '{1'b0, '{8'd80, 8'd200, 8'd100, 8'd100, 5'd3, 6'd2}, '0},
        '{1'b0, '{8'd75, 8'd60, 8'd50, 8'd50, 5'd15, 6'd0}, '0},
        '{1'b0, '{8'd75, 8'd90, 8'd7, 8'd8, 5'd3, 6'd3}, '0},
        '{1'b0, '{8'd75, 8'd170, 8'd17, 8'd33, 5'd8, 6'd4}, '0},
        '{1'b0, '{8'd75, 8'd85, 8'd64, 8'd64, 5'd12, 6'd30}, '0},
        '{1'b0, '{8'd110, 8'd95, 8'd200, 8'd10, 5'd20, 6'd15}, '0},
        '{1'b0, '{8'd109, 8'd100, 8'd20, 8'd240, 5'd2, 6'd45}, '0},
        '{1'b0, '{8'd108, 8'd105, 8'd90, 8'd91, 5'd4, 6'd8}, '0},
        '{1'b0, '{8'd81, 8'd77, 8'd33, 8'd66, 5'd5, 6'd16}, '0},
        '{1'b0, '{8'd80, 8'd76, 8'd44, 8'd22, 5'd6, 6'd31}, '0},
        '{1'b0, '{8'd81, 8'd78, 8'd11, 8'd99, 5'd7, 6'd40}, '0},
        '{1'b0, '{8'd82, 8'd79, 8'd150, 8'd160, 5'd9, 6'd50}, '0},
        '{1'b0, '{8'd100, 8'd125, 8'd240, 8'd230, 5'd24, 6'd60}, '0}
    };

    cabinet_thermostat_with_sensor_failover u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_sensor_a_code  (in_word.sens_a),
        .i_sensor_b_code  (in_word.sens_b),
        .i_supply_a_code  (in_word.sup_a),
        .i_supply_b_code  (in_word.sup_b),
        .i_hour           (in_word.hour),
        .i_minute         (in_word.minute),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_temperature    (o_temperature),
        .o_fan_on         (o_fan_on),
        .o_fan_command    (o_fan_command),
        .o_heater_on      (o_heater_on),
        .o_heater_command (o_heater_command),
        .o_active_sensor  (o_active_sensor),
        .o_status_flags   (o_status_flags),
        .o_error_count    (o_error_count),
        .o_sample_accepted(o_sample_accepted),
        .o_supply_a_volts (o_supply_a_volts),
        .o_supply_b_volts (o_supply_b_volts),
        .o_history_newest (o_history_newest)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // reading as the block reports it from the current state
    function automatic t_reading reading_now(input int temp, input bit fcmd, input bit hcmd,
                                             input bit acc);
        t_reading r;
        r.temperature = tct_pkg::t_temp'(temp);
        r.fan_on      = fan_relay;
        r.fan_cmd     = fcmd;
        r.heater_on   = heat_relay;
        r.heater_cmd  = hcmd;
        r.sensor      = sensor_in_use;
        r.flags       = fault_bits;
        r.errs        = err_cnt;
        r.accepted    = acc;
        r.volts_a     = volts_a;
        r.volts_b     = volts_b;
        r.newest      = temp_log[0];
        return r;
    endfunction

    // advance the thermostat by one sample and return its reading
    function automatic t_reading thermostat_next(input t_sample s);
        int temp;
        int fth;
        int hth;
        bit win_am;
        bit win_pm;
        bit fcmd;
        bit hcmd;
        fth  = fan_limit;
        hth  = heat_limit;
        fcmd = 1'b0;
        hcmd = 1'b0;

        // both sensors gone: relays forced off, nothing else moves
        if (sensor_in_use == tct_pkg::SEL_FAILED) begin
            fan_relay  = 1'b0;
            heat_relay = 1'b0;
            return reading_now(0, 1'b1, 1'b1, 1'b0);
        end

        temp = (sensor_in_use == tct_pkg::SEL_FIRST) ? int'(s.sens_a) : int'(s.sens_b);
        temp = temp - tct_pkg::CODE_OFFSET;

        // history shifts once per period + 1 samples
        if (hist_tick > tct_pkg::HISTORY_PERIOD) begin
            for (int k = tct_pkg::HISTORY_DEPTH - 1; k > 0; k--) temp_log[k] = temp_log[k - 1];
            temp_log[0] = tct_pkg::t_temp'(temp);
            hist_tick = 0;
        end
        hist_tick++;

        // failover on too many errors; this sample still uses the old temperature
        if (err_cnt > tct_pkg::ERROR_LIMIT) begin
            if (sensor_in_use == tct_pkg::SEL_FIRST) begin
                sensor_in_use = tct_pkg::SEL_SECOND;
                fault_bits[tct_pkg::FLAG_FAILED_OVER] = 1'b1;
                err_cnt = '0;
            end else begin
                sensor_in_use = tct_pkg::SEL_FAILED;
                fault_bits[tct_pkg::FLAG_BOTH_FAILED] = 1'b1;
                fan_relay  = 1'b0;
                heat_relay = 1'b0;
                return reading_now(0, 1'b1, 1'b1, 1'b0);
            end
        end

        // implausible reading
        if (temp > tct_pkg::TEMP_HIGH_LIMIT || temp < tct_pkg::TEMP_LOW_LIMIT) begin
            if (err_cnt != tct_pkg::ERROR_MAX) err_cnt++;
            return reading_now(temp, 1'b0, 1'b0, 1'b0);
        end

        // stuck reading check across the two daily windows
        win_am = (s.hour == tct_pkg::WINDOW_HOUR_AM) && (s.minute < tct_pkg::WINDOW_MINUTES);
        win_pm = (s.hour == tct_pkg::WINDOW_HOUR_PM) && (s.minute < tct_pkg::WINDOW_MINUTES);
        if (win_am) morning_temp = temp;
        if (win_pm) afternoon_temp = temp;
        if (warm_cnt < tct_pkg::WARMUP_SAMPLES) begin
            warm_cnt++;
        end else if ((win_am || win_pm) && morning_temp == afternoon_temp) begin
            if (err_cnt != tct_pkg::ERROR_MAX) err_cnt++;
            return reading_now(temp, 1'b0, 1'b0, 1'b0);
        end
        err_cnt = '0;

        // fan with hysteresis and repeat limit
        if (temp >= fth) begin
            if (rep_count[0] < tct_pkg::REPEAT_LIMIT) begin
                fan_relay = 1'b1;
                rep_count[0]++;
                rep_count[1] = 0;
                fcmd = 1'b1;
            end
        end else if (temp < fth - 1) begin
            if (rep_count[1] < tct_pkg::REPEAT_LIMIT) begin
                fan_relay = 1'b0;
                rep_count[1]++;
                rep_count[0] = 0;
                fcmd = 1'b1;
            end
        end

        // heater with hysteresis and repeat limit
        if (temp <= hth) begin
            if (rep_count[2] < tct_pkg::REPEAT_LIMIT) begin
                heat_relay = 1'b1;
                rep_count[2]++;
                rep_count[3] = 0;
                hcmd = 1'b1;
            end
        end else if (temp > hth + 1) begin
            if (rep_count[3] < tct_pkg::REPEAT_LIMIT) begin
                heat_relay = 1'b0;
                rep_count[3]++;
                rep_count[2] = 0;
                hcmd = 1'b1;
            end
        end

        volts_a = 8'((int'(s.sup_a) * 16 / 100) * 25 / 15);
        volts_b = 8'((int'(s.sup_b) * 16 / 100) * 128 / 16);
        return reading_now(temp, fcmd, hcmd, 1'b1);
    endfunction

    // converter code: in range around lo..hi degrees, or implausible
    function automatic logic [7:0] sensor_code(input bit bad, input int lo, input int hi);
        if (bad) begin
            if ($urandom_range(0, 1)) return 8'($urandom_range(0, 62));
            return 8'($urandom_range(121, 255));
        end
        return 8'($urandom_range(lo + 75, hi + 75));
    endfunction

    // random sample, leaning on the daily windows
    function automatic t_sample random_sample(input bit bad, input int lo, input int hi);
        t_sample s;
        s.sens_a = sensor_code(bad, lo, hi);
        s.sens_b = sensor_code(bad, lo, hi);
        s.sup_a  = 8'($urandom_range(0, 255));
        s.sup_b  = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) < 3)
            s.hour = $urandom_range(0, 1) ? tct_pkg::WINDOW_HOUR_AM : tct_pkg::WINDOW_HOUR_PM;
        else
            s.hour = 5'($urandom_range(0, 31));
        s.minute = $urandom_range(0, 1) ? 6'($urandom_range(0, 3)) : 6'($urandom_range(0, 63));
        return s;
    endfunction

    // offer one word, wait for it to be taken, then record what it must produce
    task automatic send_sample(input t_sample s, input bit dense, input bit typed,
                               input t_reading typed_want);
        int gap;
        t_reading predicted;
        gap = dense ? 0 : idle_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        in_word    <= s;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = thermostat_next(s);
        due_readings.push_back(typed ? typed_want : predicted);
    endtask

    // threshold writes only once the block has drained
    task automatic write_thresholds(input tct_pkg::t_temp fan_th,
                                    input tct_pkg::t_temp heat_th);
        while (due_readings.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= tct_pkg::CFG_FAN_TH;
        i_cfg_data  <= fan_th;
        @(posedge i_clk);
        i_cfg_index <= tct_pkg::CFG_HEATER_TH;
        i_cfg_data  <= heat_th;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        fan_limit  = fan_th;
        heat_limit = heat_th;
    endtask

    // one phase: thresholds, then n samples with short error bursts or all bad
    task automatic run_phase(input tct_pkg::t_temp fan_th, input tct_pkg::t_temp heat_th,
                             input int n, input bit all_bad, input int lo, input int hi,
                             input bit dense);
        int burst;
        bit bad;
        write_thresholds(fan_th, heat_th);
        burst = 0;
        for (int k = 0; k < n; k++) begin
            if (!all_bad && burst == 0 && $urandom_range(0, 99) < 3)
                burst = $urandom_range(1, 4);
            bad = all_bad || burst != 0;
            if (burst != 0) burst--;
            send_sample(random_sample(bad, lo, hi), dense, 1'b0, '0);
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result side back-pressure: stall runs and ready runs of random length
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (i_out_ready) begin
            i_out_ready <= 1'b0;
            ready_hold  <= idle_len();
        end else begin
            i_out_ready <= 1'b1;
            ready_hold  <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 30);
        end
    end

    // compare each taken result word with the oldest owed reading
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_readings.size() == 0) begin
                $display("%0t: unexpected result word, temperature %0d", $time, o_temperature);
                mismatches++;
            end else begin
                want = due_readings.pop_front();
                check_field("temperature", want.temperature, o_temperature);
                check_field("fan_on", want.fan_on, o_fan_on);
                check_field("fan_command", want.fan_cmd, o_fan_command);
                check_field("heater_on", want.heater_on, o_heater_on);
                check_field("heater_command", want.heater_cmd, o_heater_command);
                check_field("active_sensor", want.sensor, o_active_sensor);
                check_field("status_flags", want.flags, o_status_flags);
                check_field("error_count", want.errs, o_error_count);
                check_field("sample_accepted", want.accepted, o_sample_accepted);
                check_field("supply_a_volts", want.volts_a, o_supply_a_volts);
                check_field("supply_b_volts", want.volts_b, o_supply_b_volts);
                check_field("history_newest", want.newest, o_history_newest);
            end
        end
    end

    // main sequence
    initial begin
        foreach (temp_log[k]) temp_log[k] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows on reset thresholds
        for (int n = 0; n < 20; n++)
            send_sample(directed_rows[n].smp, 1'b0, directed_rows[n].typed,
                        directed_rows[n].want);
        i_in_valid <= 1'b0;

        // first sensor: default, extreme and narrow thresholds
        run_phase(9'sd35, 9'sd5, 200, 1'b0, -12, 45, 1'b0);
        run_phase(9'sd180, -9'sd75, 120, 1'b0, -12, 45, 1'b0);
        run_phase(-9'sd75, 9'sd180, 120, 1'b0, -12, 45, 1'b1);
        run_phase(9'sd20, 9'sd10, 300, 1'b0, 8, 22, 1'b0);

        // failover to the second sensor, then run on it
        run_phase(9'sd20, 9'sd10, 8, 1'b1, 0, 0, 1'b0);
        run_phase(9'h100, 9'sd255, 150, 1'b0, -12, 45, 1'b0);
        run_phase(9'sd16, 9'sd16, 150, 1'b0, 15, 17, 1'b1);

        // both sensors fail, then samples in the failed state
        run_phase(9'sd35, 9'sd5, 10, 1'b1, 0, 0, 1'b0);
        run_phase(9'sd35, 9'sd5, 30, 1'b0, -12, 45, 1'b0);

        while (due_readings.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
